// ===== hdl/rld_pkg.sv =====
// Package with the shared types and constants of the run-length line image decoder.
package rld_pkg;

    // Field widths of the coded stream and of the span results.
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned CURSOR_W  = 13;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SKIP_W    = 17;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT  = 3'd5;

    // Reset values of the clip registers.
    localparam logic [COORD_W-1:0] CLIP_WIDTH_RST  = 12'd320;
    localparam logic [COORD_W-1:0] CLIP_HEIGHT_RST = 12'd200;

    // Longest span one code byte can describe.
    localparam logic [BYTE_W-1:0] MAX_RUN = 8'd128;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HLO  = 3'd1,
        PH_HHI  = 3'd2,
        PH_SKIP = 3'd3,
        PH_CODE = 3'd4,
        PH_FILL = 3'd5,
        PH_LIT  = 3'd6,
        PH_DONE = 3'd7
    } t_phase;

    // One beat of the coded stream.
    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              start_image;
    } t_in;

    // One beat of span results.
    typedef struct packed {
        logic [COORD_W-1:0] span_x;
        logic [COORD_W-1:0] span_y;
        logic [BYTE_W-1:0]  span_length;
        logic [BYTE_W-1:0]  pixel_color;
        logic               image_done;
    } t_out;

    // Configuration register set.
    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] image_width;
        logic [COORD_W-1:0] image_height;
        logic [COORD_W-1:0] clip_width;
        logic [COORD_W-1:0] clip_height;
    } t_cfg;

endpackage

// ===== hdl/rld_cfg.sv =====
// Configuration register file of the run-length line image decoder.
module rld_cfg
    import rld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Registers are written one at a time; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.image_width  <= '0;
            r_cfg.image_height <= '0;
            r_cfg.clip_width   <= CLIP_WIDTH_RST;
            r_cfg.clip_height  <= CLIP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_data;
                CFG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_data;
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                CFG_CLIP_WIDTH:   r_cfg.clip_width   <= i_cfg_data;
                CFG_CLIP_HEIGHT:  r_cfg.clip_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/rld_decode.sv =====
// Parser state and per-byte decode logic of the run-length line image decoder.
module rld_decode
    import rld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_byte,
    input  t_cfg i_cfg,
    output logic o_res_valid,
    output t_out o_res
);

    // Parser state.
    t_phase               r_phase,     n_phase;
    logic [COORD_W-1:0]   r_pix_left,  n_pix_left;
    logic [CURSOR_W-1:0]  r_cursor_x,  n_cursor_x;
    logic [CURSOR_W-1:0]  r_cursor_y,  n_cursor_y;
    logic [COORD_W-1:0]   r_lines,     n_lines;
    logic [BYTE_W-1:0]    r_run,       n_run;
    logic [SKIP_W-1:0]    r_skip,      n_skip;
    logic [BYTE_W-1:0]    r_hdr_lo,    n_hdr_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pix_left <= '0;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_lines    <= '0;
            r_run      <= '0;
            r_skip     <= '0;
            r_hdr_lo   <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_pix_left <= n_pix_left;
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_lines    <= n_lines;
            r_run      <= n_run;
            r_skip     <= n_skip;
            r_hdr_lo   <= n_hdr_lo;
        end
    end

    // Next state and span result for the byte in the input register.
    always_comb begin
        t_phase              ph;
        logic                done;
        logic [BYTE_W-1:0]   wlen;
        logic [BYTE_W-1:0]   num;
        logic [BYTE_W-1:0]   code_len;
        logic [COORD_W-1:0]  avail;
        logic                line_end;
        logic                in_clip;
        logic [COORD_W-1:0]  lines_dec;
        logic [SKIP_W-1:0]   hdr;

        n_phase    = r_phase;
        n_pix_left = r_pix_left;
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_lines    = r_lines;
        n_run      = r_run;
        n_skip     = r_skip;
        n_hdr_lo   = r_hdr_lo;
        ph         = r_phase;
        done       = 1'b0;
        wlen       = '0;
        line_end   = 1'b0;
        num        = '0;
        avail      = '0;
        in_clip    = 1'b0;
        lines_dec  = '0;
        hdr        = '0;
        code_len   = {1'b0, i_byte.code_byte[BYTE_W-1:1]} + 8'd1;

        // A start restarts the image and, if not empty, is the first header byte.
        if (i_byte.start_image) begin
            n_lines    = i_cfg.image_height;
            n_cursor_y = {1'b0, i_cfg.origin_y};
            n_cursor_x = '0;
            n_pix_left = '0;
            n_run      = '0;
            n_skip     = '0;
            n_hdr_lo   = '0;
            if (i_cfg.image_height == '0 || i_cfg.image_width == '0) begin
                n_phase = PH_DONE;
                done    = 1'b1;
                ph      = PH_IDLE;
            end else begin
                ph = PH_HLO;
            end
        end

        unique case (ph)
            PH_HLO: begin
                n_hdr_lo = i_byte.code_byte;
                n_phase  = PH_HHI;
            end
            PH_HHI: begin
                if (n_cursor_y >= {1'b0, i_cfg.clip_height}) begin
                    hdr    = {1'b0, i_byte.code_byte, n_hdr_lo};
                    n_skip = hdr;
                    if (hdr == '0) begin
                        line_end = 1'b1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    n_pix_left = i_cfg.image_width;
                    n_cursor_x = {1'b0, i_cfg.origin_x};
                    n_phase    = PH_CODE;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 17'd1;
                if (n_skip == '0) begin
                    line_end = 1'b1;
                end
            end
            PH_CODE: begin
                // Clamp the run to what is left of the line.
                if ({4'b0, code_len} > r_pix_left) begin
                    num = r_pix_left[BYTE_W-1:0];
                end else begin
                    num = code_len;
                end
                n_pix_left = r_pix_left - {4'b0, num};
                n_run      = num;
                n_phase    = i_byte.code_byte[0] ? PH_FILL : PH_LIT;
                if (num == '0) begin
                    line_end = 1'b1;
                end
            end
            PH_FILL: begin
                in_clip = r_cursor_x < {1'b0, i_cfg.clip_width};
                if (in_clip) begin
                    // The cursor is inside the clip here, so its top bit is clear.
                    avail = i_cfg.clip_width - r_cursor_x[COORD_W-1:0];
                    if ({4'b0, r_run} < avail) begin
                        wlen = r_run;
                    end else begin
                        wlen = avail[BYTE_W-1:0];
                    end
                end
                n_cursor_x = r_cursor_x + {5'b0, r_run};
                n_run      = '0;
                if (r_pix_left == '0) begin
                    line_end = 1'b1;
                end else begin
                    n_phase = PH_CODE;
                end
            end
            PH_LIT: begin
                in_clip = r_cursor_x < {1'b0, i_cfg.clip_width};
                if (in_clip) begin
                    wlen = 8'd1;
                end
                n_cursor_x = r_cursor_x + 13'd1;
                n_run      = r_run - 8'd1;
                if (n_run == '0) begin
                    if (r_pix_left == '0) begin
                        line_end = 1'b1;
                    end else begin
                        n_phase = PH_CODE;
                    end
                end
            end
            PH_IDLE, PH_DONE: ;
            default: ;
        endcase

        // Close the line; the last one finishes the image.
        if (line_end) begin
            lines_dec  = n_lines - 12'd1;
            n_lines    = lines_dec;
            n_cursor_y = n_cursor_y + 13'd1;
            if (lines_dec == '0) begin
                n_phase = PH_DONE;
                done    = 1'b1;
            end else begin
                n_phase = PH_HLO;
            end
        end

        o_res_valid       = (wlen != '0) || done;
        o_res.span_length = wlen;
        o_res.image_done  = done;
        if (wlen != '0) begin
            o_res.span_x      = r_cursor_x[COORD_W-1:0];
            o_res.span_y      = r_cursor_y[COORD_W-1:0];
            o_res.pixel_color = i_byte.code_byte;
        end else begin
            o_res.span_x      = '0;
            o_res.span_y      = '0;
            o_res.pixel_color = '0;
        end
    end

endmodule

// ===== hdl/rle_line_image_decoder_core.sv =====
// Top level of the run-length line image decoder: input and result registers around the parser.
//
// The decoder takes one coded byte per clock and gives at most one span beat per byte; the
// byte is decoded from the input register and its beat is held in the result register. A
// full byte per cycle is sustained as long as the consumer keeps i_out_ready high; while a
// result beat waits, the byte in the input register holds and the input stalls, so at most
// one byte is buffered behind the waiting beat. Each line opens with a two-byte little-endian
// header; lines whose row is at or beyond clip_height are passed over by the byte count in
// that header, all other lines are decoded over image_width pixels. Spans are clipped to
// clip_width, and the beat that ends the last line carries image_done.
// Configuration may be written only between images.
module rle_line_image_decoder_core
    import rld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic fire;
    logic res_valid;
    t_out res;

    rld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The held byte is decoded once the result register has room.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    rld_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // A beat that writes no pixel can only be the end-of-image mark.
    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.span_length == '0 |-> o_out.image_done)
        else $error("result beat without pixels and without done mark");

    // A beat without pixels carries zero coordinates and colour.
    a_empty_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.span_length == '0
            |-> o_out.span_x == '0 && o_out.span_y == '0 && o_out.pixel_color == '0)
        else $error("empty result beat carries a stale payload");

    // No code byte describes more than the longest run.
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.span_length <= MAX_RUN)
        else $error("span longer than the longest run");

    // A byte that cannot be decoded stays in the input register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in))
        else $error("held byte lost from the input register");
`endif

endmodule

// ===== dv/tb_rle_line_image_decoder_core.sv =====
// Self-checking testbench for the run-length line image decoder core.
`timescale 1ns / 1ps

module tb_rle_line_image_decoder_core;
    import rld_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned N_SETTINGS   = 12;
    localparam int unsigned PER_SETTING  = 95;
    localparam int unsigned HOLD_SETTING = 4;

    localparam t_out DONE_SPAN = '{span_x: '0, span_y: '0, span_length: '0,
                                   pixel_color: '0, image_done: 1'b1};

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } t_row_kind;

    // One line of the directed script: a register write or a coded byte.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in                   beat;
        bit                    typed;
        bit                    typed_emits;
        t_out                  typed_span;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in                   i_in = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out;

    // Shadow of the register file and of the parser state.
    t_cfg                 regs;
    t_phase               dec_phase;
    logic [COORD_W-1:0]   dec_px_left;
    logic [CURSOR_W-1:0]  dec_col;
    logic [CURSOR_W-1:0]  dec_row;
    logic [COORD_W-1:0]   dec_rows_left;
    logic [BYTE_W-1:0]    dec_run;
    logic [SKIP_W-1:0]    dec_skip;
    logic [BYTE_W-1:0]    dec_hdr_lo;

    t_out        pending_spans[$];
    t_row        script[$];
    int unsigned fail_count = 0;
    int unsigned spans_seen = 0;
    int unsigned bytes_taken = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    bit          hold_request = 1'b0;
    bit          idling_on = 1'b1;

    rle_line_image_decoder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Closes the current line; returns 1 when it was the last line of the image.
    function automatic bit close_line();
        dec_rows_left = dec_rows_left - 1'b1;
        dec_row = dec_row + 1'b1;
        if (dec_rows_left == '0) begin
            dec_phase = PH_DONE;
            return 1'b1;
        end
        dec_phase = PH_HLO;
        return 1'b0;
    endfunction

    // Advances the parser shadow by one coded byte and works out the span it gives.
    function automatic void decode_byte(input t_in beat, output bit emits, output t_out span);
        logic [BYTE_W-1:0]   wlen;
        logic [CURSOR_W-1:0] wx;
        logic [CURSOR_W-1:0] wy;
        logic [BYTE_W-1:0]   wcol;
        logic [CURSOR_W-1:0] room;
        int unsigned         num;
        bit                  done;
        wlen = '0;
        wx = '0;
        wy = '0;
        wcol = '0;
        done = 1'b0;
        emits = 1'b0;
        span = '0;

        // A start beat always restarts, and an empty image ends on the spot.
        if (beat.start_image) begin
            dec_rows_left = regs.image_height;
            dec_row = {1'b0, regs.origin_y};
            dec_col = '0;
            dec_px_left = '0;
            dec_run = '0;
            dec_skip = '0;
            dec_hdr_lo = '0;
            if (regs.image_height == '0 || regs.image_width == '0) begin
                dec_phase = PH_DONE;
                done = 1'b1;
            end else begin
                dec_phase = PH_HLO;
            end
        end

        if (!done) begin
            case (dec_phase)
                PH_HLO: begin
                    dec_hdr_lo = beat.code_byte;
                    dec_phase = PH_HHI;
                end
                PH_HHI: begin
                    if (dec_row >= {1'b0, regs.clip_height}) begin
                        dec_skip = {1'b0, beat.code_byte, dec_hdr_lo};
                        if (dec_skip == '0) done = close_line();
                        else dec_phase = PH_SKIP;
                    end else begin
                        dec_px_left = regs.image_width;
                        dec_col = {1'b0, regs.origin_x};
                        dec_phase = PH_CODE;
                    end
                end
                PH_SKIP: begin
                    dec_skip = dec_skip - 1'b1;
                    if (dec_skip == '0) done = close_line();
                end
                PH_CODE: begin
                    num = beat.code_byte[7:1] + 1;
                    if (num > dec_px_left) num = dec_px_left;
                    dec_px_left = dec_px_left - COORD_W'(num);
                    dec_run = BYTE_W'(num);
                    dec_phase = beat.code_byte[0] ? PH_FILL : PH_LIT;
                    if (num == 0) done = close_line();
                end
                PH_FILL: begin
                    if (dec_col < {1'b0, regs.clip_width}) begin
                        room = {1'b0, regs.clip_width} - dec_col;
                        wlen = (dec_run < room) ? dec_run : BYTE_W'(room);
                        wx = dec_col;
                        wy = dec_row;
                        wcol = beat.code_byte;
                    end
                    dec_col = dec_col + CURSOR_W'(dec_run);
                    dec_run = '0;
                    if (dec_px_left == '0) done = close_line();
                    else dec_phase = PH_CODE;
                end
                PH_LIT: begin
                    if (dec_col < {1'b0, regs.clip_width}) begin
                        wlen = 8'd1;
                        wx = dec_col;
                        wy = dec_row;
                        wcol = beat.code_byte;
                    end
                    dec_col = dec_col + 1'b1;
                    dec_run = dec_run - 1'b1;
                    if (dec_run == '0) begin
                        if (dec_px_left == '0) done = close_line();
                        else dec_phase = PH_CODE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (wlen != '0 || done) begin
            emits = 1'b1;
            if (wlen != '0) begin
                span.span_x = wx[COORD_W-1:0];
                span.span_y = wy[COORD_W-1:0];
                span.span_length = wlen;
                span.pixel_color = wcol;
            end
            span.image_done = done;
        end
    endfunction

    // Builds a mostly well-formed next byte from where the parser stands.
    function automatic t_in shape_byte();
        t_in         beat;
        int unsigned roll;
        bit          skipping;
        beat.code_byte = 8'($urandom);
        beat.start_image = 1'b0;
        roll = $urandom_range(0, 199);
        if (dec_phase inside {PH_IDLE, PH_DONE})
            skipping = regs.origin_y >= regs.clip_height;
        else
            skipping = dec_row >= {1'b0, regs.clip_height};

        case (dec_phase)
            PH_IDLE, PH_DONE: begin
                // Most beats open a new image; the rest are noise to be ignored.
                beat.start_image = (roll >= 20);
                if (skipping) beat.code_byte = 8'($urandom_range(0, 5));
            end
            PH_HLO: begin
                if (skipping && roll != 0) beat.code_byte = 8'($urandom_range(0, 5));
            end
            PH_HHI: begin
                if (skipping) beat.code_byte = (roll == 0) ? 8'h01 : 8'h00;
            end
            PH_CODE: begin
                // Long lines are covered mainly by full fills to keep the run short.
                if (dec_px_left > 12'd256 && roll < 180) beat.code_byte = 8'hFF;
                else if (roll < 100) beat.code_byte = 8'($urandom_range(0, 31));
            end
            default: begin
            end
        endcase

        if (!(dec_phase inside {PH_IDLE, PH_DONE}) && roll == 199) beat.start_image = 1'b1;
        return beat;
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_row r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        script.push_back(r);
    endfunction

    function automatic void row_byte(input logic [7:0] code, input logic st);
        t_row r = '0;
        r.kind = ROW_BEAT;
        r.beat = '{code_byte: code, start_image: st};
        script.push_back(r);
    endfunction

    function automatic void row_known(input logic [7:0] code, input logic st,
                                      input bit emits, input t_out span);
        t_row r = '0;
        r.kind = ROW_BEAT;
        r.beat = '{code_byte: code, start_image: st};
        r.typed = 1'b1;
        r.typed_emits = emits;
        r.typed_span = span;
        script.push_back(r);
    endfunction

    // Drives one register write and lets it take at the next edge; the caller lowers the enable.
    task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ORIGIN_X:     regs.origin_x = val;
            CFG_ORIGIN_Y:     regs.origin_y = val;
            CFG_IMAGE_WIDTH:  regs.image_width = val;
            CFG_IMAGE_HEIGHT: regs.image_height = val;
            CFG_CLIP_WIDTH:   regs.clip_width = val;
            CFG_CLIP_HEIGHT:  regs.clip_height = val;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_cfg c);
        load_reg(CFG_ORIGIN_X, c.origin_x);
        load_reg(CFG_ORIGIN_Y, c.origin_y);
        load_reg(CFG_IMAGE_WIDTH, c.image_width);
        load_reg(CFG_IMAGE_HEIGHT, c.image_height);
        load_reg(CFG_CLIP_WIDTH, c.clip_width);
        load_reg(CFG_CLIP_HEIGHT, c.clip_height);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offers one coded beat, waits for it to be taken and records the span it should give.
    task automatic send_beat(input t_in beat, input bit typed, input bit typed_emits,
                             input t_out typed_span);
        bit   emits;
        t_out span;
        if (idling_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        if (beat.start_image || !(dec_phase inside {PH_IDLE, PH_DONE})) bytes_taken++;
        decode_byte(beat, emits, span);
        if (typed) begin
            emits = typed_emits;
            span = typed_span;
        end
        if (emits) pending_spans.push_back(span);
    endtask

    // Stops offering and waits until every span has come back and the pipeline is empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_cfg pick_cfg(input int unsigned p);
        t_cfg c;
        c.origin_x = 12'($urandom_range(0, 300));
        c.origin_y = 12'($urandom_range(0, 250));
        c.image_width = 12'($urandom_range(1, 48));
        c.image_height = 12'($urandom_range(1, 6));
        c.clip_width = 12'($urandom_range(0, 360));
        c.clip_height = 12'($urandom_range(0, 260));
        case (p)
            0: begin
                // One full-width line with nothing clipped.
                c.origin_x = '0;
                c.origin_y = '0;
                c.image_width = 12'd4095;
                c.image_height = 12'd1;
                c.clip_width = 12'd4095;
                c.clip_height = 12'd4095;
            end
            1: begin
                // Far corner: the last columns and rows before the clip.
                c.origin_x = 12'd4090;
                c.origin_y = 12'd4093;
                c.image_height = 12'($urandom_range(2, 5));
                c.clip_width = 12'd4095;
                c.clip_height = 12'd4095;
            end
            2: begin
                c.clip_width = '0;
                c.clip_height = '0;
            end
            3: c.image_width = '0;
            5: c.image_height = '0;
            default: begin
            end
        endcase
        return c;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Matches a received span beat against the oldest outstanding one.
    task automatic check_span(input t_out got);
        t_out want;
        spans_seen++;
        if (pending_spans.size() == 0) begin
            $error("span beat with nothing outstanding: x %0d y %0d len %0d done %0b",
                   got.span_x, got.span_y, got.span_length, got.image_done);
            fail_count++;
        end else begin
            want = pending_spans.pop_front();
            compare_field("span_x", want.span_x, got.span_x);
            compare_field("span_y", want.span_y, got.span_y);
            compare_field("span_length", want.span_length, got.span_length);
            compare_field("pixel_color", want.pixel_color, got.pixel_color);
            compare_field("image_done", want.image_done, got.image_done);
        end
    endtask

    // Result side: check each accepted beat, then decide the ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_span(o_out);
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout with %0d span beats outstanding", pending_spans.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned goal;
        regs = '{origin_x: '0, origin_y: '0, image_width: '0, image_height: '0,
                 clip_width: CLIP_WIDTH_RST, clip_height: CLIP_HEIGHT_RST};
        dec_phase = PH_IDLE;
        dec_px_left = '0;
        dec_col = '0;
        dec_row = '0;
        dec_rows_left = '0;
        dec_run = '0;
        dec_skip = '0;
        dec_hdr_lo = '0;

        // Directed script. Out of reset the image size is zero, so a start ends at once.
        row_known(8'h00, 1'b1, 1'b1, DONE_SPAN);
        row_known(8'hFF, 1'b0, 1'b0, '0);
        // Three lines at the clip corner: two decoded, the third passed over by header.
        row_cfg(CFG_ORIGIN_X, 12'd316);
        row_cfg(CFG_ORIGIN_Y, 12'd198);
        row_cfg(CFG_IMAGE_WIDTH, 12'd8);
        row_cfg(CFG_IMAGE_HEIGHT, 12'd3);
        row_byte(8'h05, 1'b1);
        row_byte(8'h00, 1'b0);
        row_byte(8'h05, 1'b0);
        row_known(8'hAB, 1'b0, 1'b1, '{span_x: 12'd316, span_y: 12'd198, span_length: 8'd3,
                                        pixel_color: 8'hAB, image_done: 1'b0});
        // Literal run longer than the line is cut; pixels past the clip are dropped.
        row_byte(8'h0E, 1'b0);
        row_byte(8'h00, 1'b0);
        row_known(8'hFF, 1'b0, 1'b0, '0);
        row_byte(8'h11, 1'b0);
        row_byte(8'h22, 1'b0);
        row_byte(8'h33, 1'b0);
        // Longest fill, cut to the line and then to the clip.
        row_byte(8'h00, 1'b0);
        row_byte(8'h00, 1'b0);
        row_byte(8'hFF, 1'b0);
        row_byte(8'h80, 1'b0);
        row_byte(8'h02, 1'b0);
        row_byte(8'h00, 1'b0);
        row_byte(8'h00, 1'b0);
        row_known(8'hFF, 1'b0, 1'b1, DONE_SPAN);
        // Every line skipped: a restart mid-image, then zero-length headers.
        row_cfg(CFG_CLIP_HEIGHT, 12'd0);
        row_cfg(CFG_IMAGE_HEIGHT, 12'd2);
        row_byte(8'h07, 1'b1);
        row_byte(8'h00, 1'b1);
        row_byte(8'h00, 1'b0);
        row_byte(8'h00, 1'b0);
        row_known(8'h00, 1'b0, 1'b1, DONE_SPAN);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the script, draining before each group of register writes.
        goal = 0;
        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                if (goal != 0) wait_drained();
                goal = 0;
                load_reg(script[k].reg_idx, script[k].reg_val);
                if (k + 1 == script.size() || script[k+1].kind != ROW_CFG) i_cfg_we <= 1'b0;
            end else begin
                send_beat(script[k].beat, script[k].typed, script[k].typed_emits,
                          script[k].typed_span);
                goal = 1;
            end
        end
        settings_used = 2;

        // Random images under a sequence of settings; every fourth one and the last run without gaps.
        for (int unsigned p = 0; p < N_SETTINGS; p++) begin
            wait_drained();
            idling_on = (p % 4 != 3) && (p != N_SETTINGS - 1);
            set_config(pick_cfg(p));
            if (p == HOLD_SETTING) hold_request = 1'b1;
            goal = bytes_taken + PER_SETTING;
            while (bytes_taken < goal || !(dec_phase inside {PH_IDLE, PH_DONE}))
                send_beat(shape_byte(), 1'b0, 1'b0, '0);
        end
        wait_drained();

        $display("Run covered %0d coded bytes under %0d register settings.",
                 bytes_taken, settings_used);
        $display("%0d span beats compared, %0d mismatches.", spans_seen, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
